FILE: src/bpr_pkg.sv
// Shared types and constants for the BMP pixel row decoder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package bpr_pkg;

  localparam int COLOR_W = 8;
  localparam int COORD_W = 12;
  localparam int RGB_W   = 3 * COLOR_W;

  // Input opcodes
  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_PIXEL   = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] REG_BPP    = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Supported pixel depths
  localparam logic [5:0] BPP_MONO  = 6'd1;
  localparam logic [5:0] BPP_NIB   = 6'd4;
  localparam logic [5:0] BPP_BYTE  = 6'd8;
  localparam logic [5:0] BPP_TRUE  = 6'd24;

  // Reset values of the configuration registers
  localparam logic [5:0]  BPP_RESET    = 6'd24;
  localparam logic [12:0] WIDTH_RESET  = 13'd640;
  localparam logic [12:0] HEIGHT_RESET = 13'd480;

  // Rounding term for 4-byte row alignment (in bits)
  localparam int ROW_ALIGN_ROUND = 31;

  typedef enum logic [2:0] {
    MODE_1,
    MODE_4,
    MODE_8,
    MODE_24,
    MODE_ERR
  } mode_t;

  // One pixel slot on its way to the output
  typedef struct packed {
    logic [RGB_W-1:0]   rgb;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] row;
    logic               row_end;
    logic               image_end;
    logic               error;
    logic               last;
    logic               use_pal;
  } pix_meta_t;

endpackage

FILE: src/bmp_pixel_row_decoder.sv
// Top level of the BMP pixel row decoder: configuration registers, input handshake,
// sequencer, palette memory and output pipe. Depends on bpr_pkg and all bpr_ modules.
`timescale 1ns / 1ps

// Decodes uncompressed BMP pixel data into 24-bit RGB pixels with column, row, row-end
// and image-end marks. Palette writes (opcode 0) are taken one per cycle while no byte
// is held or the held byte finishes, and give no result. A data byte (opcode 1) ends in
// a single step at 8 and 24 bpp and for a byte that yields no pixel (padding, columns
// past the width); at 1 and 4 bpp it takes one step per pixel it yields, up to 8 and 2,
// because the palette memory has a single read port and serves one lookup per cycle.
// Results pass from the hold stage to the palette read stage and then to the output
// register. An unsupported depth gives one error result per byte. The palette has no
// reset: reading an entry before it is written returns whatever the memory holds.
// Configuration writes are taken every cycle and must be done while the block is idle.
module bmp_pixel_row_decoder
  import bpr_pkg::*;
#(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               opcode,
  input  logic [COLOR_W-1:0] palette_index,
  input  logic [COLOR_W-1:0] palette_red,
  input  logic [COLOR_W-1:0] palette_green,
  input  logic [COLOR_W-1:0] palette_blue,
  input  logic [COLOR_W-1:0] data_byte,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [COLOR_W-1:0] red,
  output logic [COLOR_W-1:0] green,
  output logic [COLOR_W-1:0] blue,
  output logic [COORD_W-1:0] column,
  output logic [COORD_W-1:0] row,
  output logic               row_end,
  output logic               image_end,
  output logic               error,
  output logic               last
);

  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int H_W    = $clog2(MAX_HEIGHT + 1);
  localparam int PROD_W = $clog2(MAX_WIDTH * 24 + 32);
  localparam int RB_W   = PROD_W - 3;
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);
  localparam int WX_W   = (COL_W > 13) ? COL_W : 13;
  localparam int HX_W   = (H_W > 13) ? H_W : 13;

  logic [5:0]        bits_per_pixel;
  logic [12:0]       image_width;
  logic [12:0]       image_height;

  mode_t             mode;
  logic [WX_W-1:0]   w_ext;
  logic [HX_W-1:0]   h_ext;
  logic [COL_W-1:0]  eff_w;
  logic [H_W-1:0]    eff_h;
  logic [PROD_W-1:0] w_prod;
  logic [PROD_W-1:0] row_bits;
  logic [RB_W-1:0]   row_bytes;

  logic              in_acc;
  logic              pal_we;
  logic              load;
  logic              adv;
  logic              seq_busy;
  logic              seq_done;
  logic              slot_valid;
  pix_meta_t         slot;
  pix_meta_t         out_meta;
  logic              rd_en;
  logic [PAL_AW-1:0] rd_addr;
  logic [RGB_W-1:0]  rdata;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_per_pixel <= BPP_RESET;
      image_width    <= WIDTH_RESET;
      image_height   <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_BPP:    bits_per_pixel <= cfg_data[5:0];
        REG_WIDTH:  image_width    <= cfg_data;
        REG_HEIGHT: image_height   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Decode depth and clamp the image size
  always_comb begin
    case (bits_per_pixel)
      BPP_MONO: mode = MODE_1;
      BPP_NIB:  mode = MODE_4;
      BPP_BYTE: mode = MODE_8;
      BPP_TRUE: mode = MODE_24;
      default:  mode = MODE_ERR;
    endcase

    w_ext = WX_W'(image_width);
    if (image_width == 13'd0) begin
      w_ext = WX_W'(1);
    end else if (w_ext > WX_W'(MAX_WIDTH)) begin
      w_ext = WX_W'(MAX_WIDTH);
    end
    eff_w = w_ext[COL_W-1:0];

    h_ext = HX_W'(image_height);
    if (image_height == 13'd0) begin
      h_ext = HX_W'(1);
    end else if (h_ext > HX_W'(MAX_HEIGHT)) begin
      h_ext = HX_W'(MAX_HEIGHT);
    end
    eff_h = h_ext[H_W-1:0];
  end

  // Stored row length in bytes, rounded up to 4-byte alignment
  always_comb begin
    case (mode)
      MODE_1:  w_prod = PROD_W'(eff_w);
      MODE_4:  w_prod = PROD_W'(eff_w) << 2;
      MODE_8:  w_prod = PROD_W'(eff_w) << 3;
      MODE_24: w_prod = (PROD_W'(eff_w) << 4) + (PROD_W'(eff_w) << 3);
      default: w_prod = '0;
    endcase
    row_bits  = w_prod + PROD_W'(ROW_ALIGN_ROUND);
    row_bytes = {row_bits[PROD_W-1:5], 2'b00};
  end

  // Input transfer: a new item enters when no byte is held or the held byte finishes this cycle
  assign in_ready = !seq_busy || (adv && seq_done);
  assign in_acc   = in_valid && in_ready;
  assign pal_we   = in_acc && (opcode == OP_PALETTE) &&
                    ({1'b0, palette_index} < 9'(PALETTE_DEPTH));
  assign load     = in_acc && (opcode == OP_PIXEL);

  bpr_pixel_seq #(
    .MAX_WIDTH     (MAX_WIDTH),
    .MAX_HEIGHT    (MAX_HEIGHT),
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .load_byte  (data_byte),
    .adv        (adv),
    .mode       (mode),
    .eff_w      (eff_w),
    .eff_h      (eff_h),
    .row_bytes  (row_bytes),
    .busy       (seq_busy),
    .done       (seq_done),
    .slot_valid (slot_valid),
    .slot       (slot),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr)
  );

  bpr_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (PAL_AW)
  ) u_ram (
    .clk   (clk),
    .we    (pal_we),
    .waddr (palette_index[PAL_AW-1:0]),
    .wdata ({palette_red, palette_green, palette_blue}),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rdata)
  );

  bpr_out_pipe u_out (
    .clk        (clk),
    .rst        (rst),
    .slot_valid (slot_valid),
    .slot       (slot),
    .rdata      (rdata),
    .out_ready  (out_ready),
    .adv        (adv),
    .out_valid  (out_valid),
    .out_meta   (out_meta)
  );

  // Result fields
  assign red       = out_meta.rgb[RGB_W-1:2*COLOR_W];
  assign green     = out_meta.rgb[2*COLOR_W-1:COLOR_W];
  assign blue      = out_meta.rgb[COLOR_W-1:0];
  assign column    = out_meta.column;
  assign row       = out_meta.row;
  assign row_end   = out_meta.row_end;
  assign image_end = out_meta.image_end;
  assign error     = out_meta.error;
  assign last      = out_meta.last;

endmodule

FILE: src/bpr_palette_ram.sv
// Palette color table: one write port, one enabled read port, registered read data.
// Depends on bpr_pkg for the color width.
`timescale 1ns / 1ps

module bpr_palette_ram
  import bpr_pkg::*;
#(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [RGB_W-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [RGB_W-1:0] rdata
);

  logic [RGB_W-1:0] mem [DEPTH];

  // Write and read in one block: a read at the write address returns the old entry
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: src/bpr_pixel_seq.sv
// Byte sequencer: holds one pixel-data byte, steps its pixels one per cycle unless stalled,
// keeps the column, row and row-byte counters and issues palette reads. Uses bpr_pkg.
`timescale 1ns / 1ps

module bpr_pixel_seq
  import bpr_pkg::*;
#(
  parameter int MAX_WIDTH     = 4096,
  parameter int MAX_HEIGHT    = 4096,
  parameter int PALETTE_DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         load,
  input  logic [COLOR_W-1:0]                           load_byte,
  input  logic                                         adv,
  input  mode_t                                        mode,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]               eff_w,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]              eff_h,
  input  logic [$clog2(MAX_WIDTH*24+32)-4:0]           row_bytes,
  output logic                                         busy,
  output logic                                         done,
  output logic                                         slot_valid,
  output pix_meta_t                                    slot,
  output logic                                         rd_en,
  output logic [$clog2(PALETTE_DEPTH)-1:0]             rd_addr
);

  localparam int COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int H_W    = $clog2(MAX_HEIGHT + 1);
  localparam int RB_W   = $clog2(MAX_WIDTH * 24 + 32) - 3;
  localparam int PAL_AW = $clog2(PALETTE_DEPTH);

  logic                 hold_valid;
  logic [COLOR_W-1:0]   hold_byte;
  logic [2:0]           sub;
  logic [COL_W-1:0]     column_count;
  logic [ROW_W-1:0]     row_count;
  logic [RB_W-1:0]      row_byte_count;
  logic [2*COLOR_W-1:0] partial;
  logic [1:0]           pcount;

  logic                 hold_valid_next;
  logic [2:0]           sub_next;
  logic [COL_W-1:0]     column_count_next;
  logic [ROW_W-1:0]     row_count_next;
  logic [RB_W-1:0]      row_byte_count_next;
  logic [2*COLOR_W-1:0] partial_next;
  logic [1:0]           pcount_next;

  logic [ROW_W-1:0]     row_eff;
  logic [H_W-1:0]       row_inc;
  logic                 row_last;
  logic                 col_in;
  logic                 col_last;
  logic [RB_W:0]        rb_next;
  logic                 row_wrap;
  logic                 emit;
  logic                 pal_mode;
  logic                 pal_ok;
  logic [COLOR_W-1:0]   idx;
  logic                 step;
  logic [COORD_W+COL_W-1:0] col_ext;
  logic [COORD_W+ROW_W-1:0] row_ext;

  assign busy = hold_valid;
  assign step = hold_valid && adv;

  // Position of the current pixel within the row and the image
  always_comb begin
    row_eff  = (H_W'(row_count) >= eff_h) ? '0 : row_count;
    row_inc  = H_W'(row_eff) + H_W'(1);
    row_last = (row_inc == eff_h);
    col_in   = (column_count < eff_w);
    col_last = (column_count == (eff_w - COL_W'(1)));
    rb_next  = (RB_W+1)'(row_byte_count) + (RB_W+1)'(1);
    row_wrap = (rb_next >= (RB_W+1)'(row_bytes));
    col_ext  = {{COORD_W{1'b0}}, column_count};
    row_ext  = {{COORD_W{1'b0}}, row_eff};
  end

  // Pick the pixel of this step and decide whether the byte is finished
  always_comb begin
    emit     = 1'b0;
    done     = 1'b1;
    pal_mode = 1'b1;
    idx      = '0;
    case (mode)
      MODE_1: begin
        idx  = {{(COLOR_W-1){1'b0}}, hold_byte[~sub]};
        emit = col_in;
        done = !col_in || (sub == 3'd7) || col_last;
      end
      MODE_4: begin
        idx  = {4'b0000, (sub[0] ? hold_byte[3:0] : hold_byte[7:4])};
        emit = col_in;
        done = !col_in || sub[0] || col_last;
      end
      MODE_8: begin
        idx  = hold_byte;
        emit = col_in;
      end
      MODE_24: begin
        pal_mode = 1'b0;
        emit     = col_in && (pcount == 2'd2);
      end
      default: begin
        pal_mode = 1'b0;
      end
    endcase
  end

  assign pal_ok     = ({1'b0, idx} < 9'(PALETTE_DEPTH));
  assign slot_valid = step && (emit || (mode == MODE_ERR));
  assign rd_en      = step && emit && pal_mode && pal_ok;
  assign rd_addr    = idx[PAL_AW-1:0];

  // Build the slot; palette pixels get their color one stage later
  always_comb begin
    slot = '0;
    if (mode == MODE_ERR) begin
      slot.error = 1'b1;
      slot.last  = 1'b1;
    end else begin
      slot.column    = col_ext[COORD_W-1:0];
      slot.row       = row_ext[COORD_W-1:0];
      slot.row_end   = col_last;
      slot.image_end = col_last && row_last;
      slot.last      = done;
      slot.use_pal   = pal_mode && pal_ok;
      if (mode == MODE_24) begin
        slot.rgb = {hold_byte, partial};
      end
    end
  end

  // Hold the byte under work
  always_ff @(posedge clk) begin
    if (load) begin
      hold_byte <= load_byte;
    end
  end

  // Next step counter and image counters
  always_comb begin
    hold_valid_next     = hold_valid;
    sub_next            = sub;
    column_count_next   = column_count;
    row_count_next      = row_count;
    row_byte_count_next = row_byte_count;
    partial_next        = partial;
    pcount_next         = pcount;
    if (step) begin
      sub_next = sub + 3'd1;
      if (done) begin
        hold_valid_next = 1'b0;
      end
      if (mode != MODE_ERR) begin
        if (emit) begin
          column_count_next = column_count + COL_W'(1);
        end
        if ((mode == MODE_24) && col_in) begin
          case (pcount)
            2'd0: begin
              partial_next = {{COLOR_W{1'b0}}, hold_byte};
              pcount_next  = 2'd1;
            end
            2'd1: begin
              partial_next[2*COLOR_W-1:COLOR_W] = hold_byte;
              pcount_next                       = 2'd2;
            end
            default: begin
              partial_next = '0;
              pcount_next  = 2'd0;
            end
          endcase
        end
        if (done) begin
          if (row_wrap) begin
            row_byte_count_next = '0;
            column_count_next   = '0;
            partial_next        = '0;
            pcount_next         = '0;
            row_count_next      = row_last ? '0 : row_inc[ROW_W-1:0];
          end else begin
            row_byte_count_next = rb_next[RB_W-1:0];
            row_count_next      = row_eff;
          end
        end
      end
    end
    if (load) begin
      hold_valid_next = 1'b1;
      sub_next        = '0;
    end
  end

  // Advance the step counter and the image counters
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid     <= 1'b0;
      sub            <= '0;
      column_count   <= '0;
      row_count      <= '0;
      row_byte_count <= '0;
      partial        <= '0;
      pcount         <= '0;
    end else begin
      hold_valid     <= hold_valid_next;
      sub            <= sub_next;
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      row_byte_count <= row_byte_count_next;
      partial        <= partial_next;
      pcount         <= pcount_next;
    end
  end

  // The partial color never counts three bytes
  assert property (@(posedge clk) disable iff (rst) pcount != 2'd3)
    else $error("partial byte count out of range");

  // Single-result depths finish their byte in one step
  assert property (@(posedge clk) disable iff (rst)
    (hold_valid && (mode == MODE_8 || mode == MODE_24 || mode == MODE_ERR)) |-> done)
    else $error("single-step byte did not finish");

  // At 4 bpp a byte has at most two steps
  assert property (@(posedge clk) disable iff (rst)
    (hold_valid && mode == MODE_4) |-> (sub[2:1] == 2'b00))
    else $error("nibble step past second pixel");

  // A palette read is issued only with a slot
  assert property (@(posedge clk) disable iff (rst) rd_en |-> slot_valid)
    else $error("palette read without pixel slot");

endmodule

FILE: src/bpr_out_pipe.sv
// Read stage and output register: joins palette read data with the pixel slot
// and presents the result. Uses bpr_pkg for the slot type.
`timescale 1ns / 1ps

module bpr_out_pipe
  import bpr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             slot_valid,
  input  pix_meta_t        slot,
  input  logic [RGB_W-1:0] rdata,
  input  logic             out_ready,
  output logic             adv,
  output logic             out_valid,
  output pix_meta_t        out_meta
);

  logic      b_valid;
  pix_meta_t b_meta;
  pix_meta_t b_join;

  // Move the whole pipe unless the output holds an untaken result
  assign adv = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      b_valid   <= slot_valid;
      out_valid <= b_valid;
    end
  end

  // Take the palette color where the slot asks for it
  always_comb begin
    b_join = b_meta;
    if (b_meta.use_pal) begin
      b_join.rgb = rdata;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (adv) begin
      b_meta   <= slot;
      out_meta <= b_join;
    end
  end

  // Error results are always the last of their byte
  assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_meta.error) |-> b_meta.last)
    else $error("error result without last");

  // A stalled output keeps the stage behind it full or empty as it was
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (b_valid == $past(b_valid)))
    else $error("read stage moved during stall");

  // Error results carry no color
  assert property (@(posedge clk) disable iff (rst)
    (b_valid && b_meta.error) |-> (b_meta.rgb == '0 && !b_meta.use_pal))
    else $error("error result with pixel data");

endmodule
